// ===== hdl/bir_pkg.sv =====
package bir_pkg;

  localparam int unsigned MaxSrcWidth  = 256;
  localparam int unsigned MaxSrcHeight = 256;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned DstLimit     = 1024;
  localparam int unsigned QueueDepth   = 4;

  typedef enum logic [1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1,
    RegDstWidth  = 2'd2,
    RegDstHeight = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdRead  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [15:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  sw;
    logic [9:0]  sh;
    logic [10:0] dw;
    logic [10:0] dh;
  } geom_t;

endpackage

// ===== hdl/bir_front.sv =====
module bir_front (
  input  logic              start,
  output logic              busy,
  input  bir_pkg::in_item_t in_i,
  input  bir_pkg::geom_t    geom_i,
  output logic              push_o,
  output logic              push_oob_o,
  output bir_pkg::in_item_t push_item_o,
  input  logic              full_i
);
  import bir_pkg::*;

  logic in_src, in_dst;

  assign busy = full_i;
  assign in_src = ({1'b0, in_i.column} < {1'b0, geom_i.sw}) &&
                  ({1'b0, in_i.row} < {1'b0, geom_i.sh});
  assign in_dst = ({1'b0, in_i.column} < geom_i.dw) && ({1'b0, in_i.row} < geom_i.dh);

  assign push_o      = start && !busy;
  assign push_oob_o  = (in_i.cmd == CmdWrite) ? !in_src : !in_dst;
  assign push_item_o = in_i;

endmodule

// ===== hdl/bir_queue.sv =====
module bir_queue #(
  parameter int unsigned Depth = bir_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              oob_i,
  input  bir_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              valid_o,
  output logic              oob_o,
  output bir_pkg::in_item_t item_o,
  input  logic              pop_i
);
  import bir_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t      mem_q [Depth];
  logic          oob_mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign oob_o   = oob_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q]     <= item_i;
      oob_mem_q[wp_q] <= oob_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

endmodule

// ===== hdl/bir_back.sv =====
module bir_back #(
  parameter int unsigned Fb = bir_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bir_pkg::geom_t     geom_i,
  input  logic               valid_i,
  input  logic               oob_i,
  input  bir_pkg::in_item_t  item_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output bir_pkg::out_item_t res_o
);
  import bir_pkg::*;

  localparam int unsigned Xw = $clog2(MaxSrcWidth);
  localparam int unsigned Yw = $clog2(MaxSrcHeight);
  localparam int unsigned Cw = 10;
  localparam int unsigned Qw = 10 + Fb;
  localparam int unsigned Pw = Cw + 10 + Fb;
  localparam logic [Fb:0] One = {1'b1, {Fb{1'b0}}};

  // divider: restoring, one quotient bit per step per axis
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StMul  = 3'b100
  } st_e;

  st_e            st_q;
  logic [Pw-1:0]  nx_q, ny_q;
  logic [Pw-1:0]  rx_q, ry_q;
  logic [Qw-1:0]  qx_q, qy_q;
  logic [10:0]    dx_q, dy_q;
  logic [5:0]     step_q;
  logic           oob_q;

  logic [15:0] bank_a [MaxSrcWidth*MaxSrcHeight];
  logic [15:0] bank_b [MaxSrcWidth*MaxSrcHeight];
  logic [15:0] bank_c [MaxSrcWidth*MaxSrcHeight];
  logic [15:0] bank_d [MaxSrcWidth*MaxSrcHeight];

  logic             wr, rd_pop;
  logic [Xw+Yw-1:0] wa;

  assign pop_o  = valid_i && (st_q == StIdle);
  assign wr     = pop_o && (item_i.cmd == CmdWrite) && !oob_i;
  assign rd_pop = pop_o && (item_i.cmd == CmdRead);
  assign wa     = {item_i.row[Yw-1:0], item_i.column[Xw-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr) begin
      bank_a[wa] <= item_i.pixel;
      bank_b[wa] <= item_i.pixel;
      bank_c[wa] <= item_i.pixel;
      bank_d[wa] <= item_i.pixel;
    end
  end

  logic [Pw:0] rx_sh, ry_sh;
  assign rx_sh = {rx_q, nx_q[Pw-1]};
  assign ry_sh = {ry_q, ny_q[Pw-1]};

  logic [19:0] px, py;
  assign px = item_i.column * (geom_i.sw - 10'd1);
  assign py = item_i.row * (geom_i.sh - 10'd1);

  logic [Qw-1:0] qx, qy;
  logic [Xw:0]   x0, x1;
  logic [Yw:0]   y0, y1;
  logic [Fb-1:0] tx, ty;
  always_comb begin
    qx = qx_q;
    qy = qy_q;
    x0 = (qx[Qw-1:Fb] > Cw'(geom_i.sw - 1'b1)) ? (Xw+1)'(geom_i.sw - 1'b1)
                                               : (Xw+1)'(qx[Qw-1:Fb]);
    y0 = (qy[Qw-1:Fb] > Cw'(geom_i.sh - 1'b1)) ? (Yw+1)'(geom_i.sh - 1'b1)
                                               : (Yw+1)'(qy[Qw-1:Fb]);
    x1 = ((Cw'(x0) + 1'b1) < geom_i.sw) ? x0 + 1'b1 : x0;
    y1 = ((Cw'(y0) + 1'b1) < geom_i.sh) ? y0 + 1'b1 : y0;
    tx = qx[Fb-1:0];
    ty = qy[Fb-1:0];
  end

  logic [15:0]   pa_q, pb_q, pc_q, pd_q;
  logic [Fb-1:0] tx_q, ty_q;
  logic          f_v_q, m_v_q, r_v_q;
  logic          f_oob_q, m_oob_q, r_oob_q;
  logic [16+Fb:0] top_q, bot_q;
  logic [16+Fb:0] ta_w, tb_w, tc_w, td_w;
  logic [Fb-1:0]  ty2_q;
  logic [16+2*Fb+1:0] sum, st_w, sb_w;
  logic [15:0]   val_q;

  always_comb begin
    ta_w = pa_q * (One - tx_q);
    tb_w = pb_q * tx_q;
    tc_w = pc_q * (One - tx_q);
    td_w = pd_q * tx_q;
    st_w = top_q * (One - ty2_q);
    sb_w = bot_q * ty2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_pop) begin
      nx_q  <= {px, {Fb{1'b0}}};
      ny_q  <= {py, {Fb{1'b0}}};
      rx_q  <= '0;
      ry_q  <= '0;
      qx_q  <= '0;
      qy_q  <= '0;
      dx_q  <= geom_i.dw - 1'b1;
      dy_q  <= geom_i.dh - 1'b1;
      oob_q <= oob_i;
    end else if (st_q == StDiv) begin
      nx_q <= nx_q << 1;
      ny_q <= ny_q << 1;
      if (rx_sh >= {{(Pw-10){1'b0}}, dx_q}) begin
        rx_q <= Pw'(rx_sh - {{(Pw-10){1'b0}}, dx_q});
        qx_q <= {qx_q[Qw-2:0], 1'b1};
      end else begin
        rx_q <= Pw'(rx_sh);
        qx_q <= {qx_q[Qw-2:0], 1'b0};
      end
      if (ry_sh >= {{(Pw-10){1'b0}}, dy_q}) begin
        ry_q <= Pw'(ry_sh - {{(Pw-10){1'b0}}, dy_q});
        qy_q <= {qy_q[Qw-2:0], 1'b1};
      end else begin
        ry_q <= Pw'(ry_sh);
        qy_q <= {qy_q[Qw-2:0], 1'b0};
      end
    end
    pa_q <= bank_a[{y0[Yw-1:0], x0[Xw-1:0]}];
    pb_q <= bank_b[{y0[Yw-1:0], x1[Xw-1:0]}];
    pc_q <= bank_c[{y1[Yw-1:0], x0[Xw-1:0]}];
    pd_q <= bank_d[{y1[Yw-1:0], x1[Xw-1:0]}];
    tx_q <= tx;
    ty_q <= ty;
    top_q <= ta_w + tb_w;
    bot_q <= tc_w + td_w;
    ty2_q <= ty_q;
    val_q <= sum[16+2*Fb-1:2*Fb];
  end

  assign sum = st_w + sb_w + ((18+2*Fb)'(1) << (2*Fb-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      step_q  <= '0;
      f_v_q   <= 1'b0;
      m_v_q   <= 1'b0;
      r_v_q   <= 1'b0;
      f_oob_q <= 1'b0;
      m_oob_q <= 1'b0;
      r_oob_q <= 1'b0;
    end else begin
      f_v_q <= (st_q == StMul);
      unique case (st_q)
        StIdle: begin
          if (rd_pop) begin
            st_q   <= StDiv;
            step_q <= 6'(Pw);
          end
        end
        StDiv: begin
          step_q <= step_q - 1'b1;
          if (step_q == 6'd1) st_q <= StMul;
        end
        StMul: begin
          st_q    <= StIdle;
          f_oob_q <= oob_q;
        end
        default: st_q <= StIdle;
      endcase
      m_v_q   <= f_v_q;
      m_oob_q <= f_oob_q;
      r_v_q   <= m_v_q;
      r_oob_q <= m_oob_q;
    end
  end

  assign res_valid_o  = r_v_q;
  assign res_o.value  = r_oob_q ? 16'd0 : val_q;
  assign res_o.status = r_oob_q;

endmodule

// ===== hdl/bilinear_image_resampler.sv =====
// Bilinear image resampler, 16-bit greyscale.
// Command channel: a transaction is taken on a clock edge with start high and busy low.
// busy rises only while the four-entry command queue is full.
// Writes and reads pass the queue in order. A write reaches the image store on the
// first idle cycle of the back end after it has left the queue; writes outside the
// source size are dropped and give no result.
// A read gives one result on result_valid_o for one cycle, with status 1 and
// value 0 if its coordinates fall outside the destination grid.
// A read runs a restoring divider, one quotient bit per cycle for both axes, a
// fetch from four replicated image banks and a two-stage multiply-add; the back
// end takes no new command from the queue until the read has left the divider.
// Writes drain from the queue at one per cycle while the back end is idle.
// Configuration: cfg_valid_i/cfg_ready_o with index and data, write when idle.
// Reset restores all sizes to 256; the image store holds no reset value.
// The receiver cannot stall results.
module bilinear_image_resampler #(
  parameter int unsigned FRAC_BITS = bir_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bir_pkg::in_item_t  in_i,
  output logic               result_valid_o,
  output bir_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bir_pkg::*;

  logic [8:0]  sw_q, sh_q;
  logic [10:0] dw_q, dh_q;
  geom_t       geom;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 9'd256;
      sh_q <= 9'd256;
      dw_q <= 11'd256;
      dh_q <= 11'd256;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegSrcWidth:  sw_q <= cfg_data_i[8:0];
        RegSrcHeight: sh_q <= cfg_data_i[8:0];
        RegDstWidth:  dw_q <= cfg_data_i[10:0];
        RegDstHeight: dh_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.sw = (sw_q == '0) ? 10'd1 : (sw_q > 9'(MaxSrcWidth)) ? 10'(MaxSrcWidth) : 10'(sw_q);
    geom.sh = (sh_q == '0) ? 10'd1 : (sh_q > 9'(MaxSrcHeight)) ? 10'(MaxSrcHeight) : 10'(sh_q);
    geom.dw = (dw_q < 11'd2) ? 11'd2 : (dw_q > 11'(DstLimit)) ? 11'(DstLimit) : dw_q;
    geom.dh = (dh_q < 11'd2) ? 11'd2 : (dh_q > 11'(DstLimit)) ? 11'(DstLimit) : dh_q;
  end

  logic     push, push_oob, full, q_valid, q_oob, pop;
  in_item_t push_item, q_item;

  bir_front u_front (
    .start, .busy, .in_i, .geom_i(geom),
    .push_o(push), .push_oob_o(push_oob),
    .push_item_o(push_item), .full_i(full)
  );

  bir_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .oob_i(push_oob), .item_i(push_item),
    .full_o(full), .valid_o(q_valid), .oob_o(q_oob), .item_o(q_item), .pop_i(pop)
  );

  bir_back #(.Fb(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .geom_i(geom),
    .valid_i(q_valid), .oob_i(q_oob), .item_i(q_item), .pop_o(pop),
    .res_valid_o(result_valid_o), .res_o(result_o)
  );

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status) |-> (result_o.value == '0))
    else $error("out of range result not zero");

endmodule
